[rtl/arinc429_word_encoder_macros.svh]
// Assertion macros used by the ARINC 429 word encoder RTL.
`ifndef ARINC429_WORD_ENCODER_MACROS_SVH
`define ARINC429_WORD_ENCODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define A429_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("a429enc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define A429_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("a429enc assertion failed");
`else
`define A429_ASSERT_NOW(lbl, ante, cons)
`define A429_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/a429enc_pkg.sv]
// Types and constants of the ARINC 429 word encoder.
package a429enc_pkg;

  // Label codes on the func input.
  localparam logic [1:0] FUNC_UNUSED = 2'd0;
  localparam logic [1:0] FUNC_ALT    = 2'd1;
  localparam logic [1:0] FUNC_CLIMB  = 2'd2;
  localparam logic [1:0] FUNC_AOA    = 2'd3;

  // Label bytes placed in bits 7..0 of the word.
  localparam logic [7:0] LABEL_ALT   = 8'h80;
  localparam logic [7:0] LABEL_CLIMB = 8'h40;
  localparam logic [7:0] LABEL_AOA   = 8'hC0;

  localparam int VALUE_W   = 27;
  localparam int WORD_W    = 32;
  localparam int BNR_W     = 16;
  localparam int BNR_CNT_W = 17;
  localparam int BCD_CNT_W = 20;

  // Number of register stages from input to output register.
  localparam int NUM_STAGES = 7;

  // Control fields that travel alongside the datapath.
  typedef struct packed {
    logic [1:0] func;
    logic       neg;
    logic [1:0] phase;
    logic       phase_present;
  } ctrl_t;

  // Result of the BNR path.
  typedef struct packed {
    logic [BNR_W-1:0] field;
    logic             exact;
  } bnr_t;

endpackage

[rtl/a429enc_bnr.sv]
// BNR path: rounded division of the magnitude by 625 and the exactness check.
module a429enc_bnr import a429enc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [VALUE_W-1:0] mag_i,
  input  logic               neg_i,
  output bnr_t               bnr_o
);

  // Reciprocal of 625 scaled by 2^36, rounded up; exact for all 27-bit dividends.
  localparam logic [53:0] RECIP_625 = 54'd109951163;
  localparam int          RECIP_SH  = 36;

  logic [VALUE_W-1:0]   x_d, x_q;
  logic [53:0]          prod;
  logic [BNR_CNT_W-1:0] cnt_d, cnt_q;
  logic [VALUE_W-1:0]   rem;
  logic                 mod_ok;
  logic                 range_ok;
  bnr_t                 bnr_d, bnr_q;

  // Stage two: add half the divisor and multiply by the reciprocal.
  always_comb begin
    x_d   = mag_i + VALUE_W'(312);
    prod  = 54'(x_d) * RECIP_625;
    cnt_d = prod[RECIP_SH+BNR_CNT_W-1:RECIP_SH];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      cnt_q <= cnt_d;
    end
  end

  // Stage three: the value is exact when the rounding offset is the whole remainder and the count is in range.
  always_comb begin
    rem    = x_q - VALUE_W'(cnt_q) * VALUE_W'(625);
    mod_ok = (rem == VALUE_W'(312));
    if (neg_i) begin
      range_ok    = (cnt_q != '0) && (cnt_q <= BNR_CNT_W'(65536));
      bnr_d.field = BNR_W'(0) - cnt_q[BNR_W-1:0];
    end else begin
      range_ok    = (cnt_q <= BNR_CNT_W'(65535));
      bnr_d.field = cnt_q[BNR_W-1:0];
    end
    bnr_d.exact = mod_ok && range_ok;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bnr_q <= bnr_d;
    end
  end

  assign bnr_o = bnr_q;

endmodule

[rtl/a429enc_bcd.sv]
// BCD path: scales the magnitude to tenths and splits it into four decimal digits.
module a429enc_bcd import a429enc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [VALUE_W-1:0] mag_i,
  output logic [15:0]        bcd_o
);

  // Reciprocals: 10000 scaled by 2^33 and 100 scaled by 2^19, both rounded up.
  localparam logic [39:0] RECIP_10K = 40'd858994;
  localparam int          SH_10K    = 33;
  localparam logic [26:0] RECIP_100 = 27'd5243;
  localparam int          SH_100    = 19;

  // Splits a value below 100 into tens and units digits.
  function automatic logic [7:0] split_two(input logic [6:0] n);
    logic [14:0] t;
    logic [3:0]  tens;
    logic [6:0]  units;
    t     = 15'(n) * 15'd205;
    tens  = t[14:11];
    units = n - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

  logic [29:0]          scaled;
  logic [BCD_CNT_W-1:0] cnt2_d, cnt2_q, cnt3_q;
  logic [39:0]          prod_10k;
  logic [6:0]           q3_d, q3_q;
  logic [BCD_CNT_W-1:0] diff4;
  logic [13:0]          r4_d, r4_q, r5_q;
  logic [26:0]          prod_100;
  logic [6:0]           h5_d, h5_q;
  logic [6:0]           lo6;
  logic [15:0]          bcd_d, bcd_q;

  // Stage two: count of tenths, round(mag * 10 / 1024).
  always_comb begin
    scaled = 30'(mag_i) * 30'd10 + 30'd512;
    cnt2_d = scaled[29:10];
  end

  // Stage three: quotient by 10000.
  always_comb begin
    prod_10k = 40'(cnt2_q) * RECIP_10K;
    q3_d     = prod_10k[SH_10K+6:SH_10K];
  end

  // Stage four: keep the low four decimal digits.
  always_comb begin
    diff4 = cnt3_q - BCD_CNT_W'(q3_q) * BCD_CNT_W'(10000);
    r4_d  = diff4[13:0];
  end

  // Stage five: quotient by 100 gives the upper digit pair.
  always_comb begin
    prod_100 = 27'(r4_q) * RECIP_100;
    h5_d     = prod_100[SH_100+6:SH_100];
  end

  // Stage six: lower digit pair and the four digits.
  always_comb begin
    lo6   = 7'(r5_q - 14'(h5_q) * 14'd100);
    bcd_d = {split_two(h5_q), split_two(lo6)};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cnt2_q <= cnt2_d;
      cnt3_q <= cnt2_q;
      q3_q   <= q3_d;
      r4_q   <= r4_d;
      r5_q   <= r4_q;
      h5_q   <= h5_d;
      bcd_q  <= bcd_d;
    end
  end

  assign bcd_o = bcd_q;

endmodule

[rtl/a429enc_pack.sv]
// Word assembly: label, data field, SSM and odd parity into the output register.
module a429enc_pack import a429enc_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  ctrl_t             ctrl_i,
  input  bnr_t              bnr_i,
  input  logic [15:0]       bcd_i,
  output logic [WORD_W-1:0] word_o
);

  logic [WORD_W-1:0] body;
  logic [WORD_W-1:0] word_d, word_q;

  // Data and status bits for each label.
  always_comb begin
    body = '0;
    case (ctrl_i.func)
      FUNC_ALT: begin
        body[7:0]   = LABEL_ALT;
        body[27:12] = bnr_i.field;
        body[28]    = ctrl_i.neg;
        if (ctrl_i.phase_present) begin
          body[11:10] = ctrl_i.phase;
        end
        body[29] = bnr_i.exact;
        body[30] = bnr_i.exact;
      end
      FUNC_CLIMB: begin
        body[7:0]   = LABEL_CLIMB;
        body[28:13] = bcd_i;
        body[29]    = ctrl_i.neg;
        body[30]    = ctrl_i.neg;
      end
      FUNC_AOA: begin
        body[7:0]   = LABEL_AOA;
        body[28:17] = bcd_i[11:0];
        body[29]    = ctrl_i.neg;
        body[30]    = ctrl_i.neg;
      end
      default: begin
        // Unused label: no computed data.
        body[29] = 1'b1;
      end
    endcase
    word_d     = body;
    word_d[31] = ~^body[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

[rtl/arinc429_word_encoder.sv]
// ARINC 429 word encoder: seven-stage pipeline, one 32-bit word per input transfer.
// Each input transfer yields one word, offered on the output when it reaches the output
// register. A new item is taken in every cycle while the output is not held off, so the
// sustained rate is one word per clock. Stage one forms the magnitude, stages two and three
// divide it by 625 for BNR with a reciprocal multiplier, stages two to six form the tenths
// count and its decimal digits with reciprocal multipliers by 10000, 100 and 10, and stage
// seven is the output register with parity. When the output is held off, the whole
// pipeline freezes and input ready drops; nothing is lost or repeated.
`include "arinc429_word_encoder_macros.svh"

module arinc429_word_encoder import a429enc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [1:0]         flight_phase_i,
  input  logic               phase_present_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [WORD_W-1:0]  word_o
);

  logic                  en;
  logic [NUM_STAGES-1:0] valid_d, valid_q;
  ctrl_t                 ctrl_d;
  ctrl_t                 ctrl_q [0:5];
  logic [VALUE_W-1:0]    mag_d, mag_q;
  bnr_t                  bnr_s3;
  bnr_t                  bnr_q [0:2];
  logic [15:0]           bcd_s6;

  // The pipeline advances whenever the output register is free or being emptied.
  assign en         = !valid_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o = en;
  assign valid_d    = {valid_q[NUM_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // Stage one: sign and magnitude of the value.
  always_comb begin
    ctrl_d.func          = func_i;
    ctrl_d.neg           = value_i[VALUE_W-1];
    ctrl_d.phase         = flight_phase_i;
    ctrl_d.phase_present = phase_present_i;
    mag_d = value_i[VALUE_W-1] ? (VALUE_W'(0) - value_i) : value_i;
  end

  // Control fields and the BNR result travel alongside the digit pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q     <= mag_d;
      ctrl_q[0] <= ctrl_d;
      for (int i = 1; i < 6; i++) begin
        ctrl_q[i] <= ctrl_q[i-1];
      end
      bnr_q[0] <= bnr_s3;
      bnr_q[1] <= bnr_q[0];
      bnr_q[2] <= bnr_q[1];
    end
  end

  a429enc_bnr u_bnr (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag_q),
    .neg_i (ctrl_q[1].neg),
    .bnr_o (bnr_s3)
  );

  a429enc_bcd u_bcd (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag_q),
    .bcd_o (bcd_s6)
  );

  a429enc_pack u_pack (
    .clk_i  (clk_i),
    .en_i   (en),
    .ctrl_i (ctrl_q[5]),
    .bnr_i  (bnr_q[2]),
    .bcd_i  (bcd_s6),
    .word_o (word_o)
  );

  assign out_valid_o = valid_q[NUM_STAGES-1];

  // True when all four nibbles are decimal digits.
  function automatic logic bcd_ok(input logic [15:0] d);
    return (d[15:12] <= 4'd9) && (d[11:8] <= 4'd9) && (d[7:4] <= 4'd9) && (d[3:0] <= 4'd9);
  endfunction

  // Every delivered word has odd parity.
  `A429_ASSERT_NOW(a_odd_parity, out_valid_o, (^word_o) == 1'b1)
  // BCD digits of a climb rate word are decimal.
  `A429_ASSERT_NOW(a_bcd_ok, out_valid_o && word_o[7:0] == LABEL_CLIMB, bcd_ok(word_o[28:13]))
  // A word that is held off stays in the output register into the next cycle.
  `A429_ASSERT_NEXT(a_hold_full, out_valid_o && !out_ready_i, out_valid_o && $stable(word_o))

endmodule

[dv/arinc429_word_encoder_tb.sv]
// Self-checking testbench for the ARINC 429 word encoder with random handshake stalls.
`timescale 1ns / 100ps

module arinc429_word_encoder_tb import a429enc_pkg::*;;

  // One input transfer of the encoder.
  typedef struct packed {
    logic [1:0]         func;
    logic [VALUE_W-1:0] value;
    logic [1:0]         phase;
    logic               phase_present;
  } enc_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         func_i = FUNC_UNUSED;
  logic [VALUE_W-1:0] value_i = '0;
  logic [1:0]         flight_phase_i = 2'd0;
  logic               phase_present_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [WORD_W-1:0]  word_o;

  enc_item_t         pending_items[$];
  logic [WORD_W-1:0] expected_words[$];
  enc_item_t         cur_item;
  int                mismatches = 0;
  bit                calm = 1'b0;
  int                src_idle_left = 0;
  int                src_idle_pct = 10;
  int                snk_idle_left = 0;
  int                snk_idle_pct = 10;

  arinc429_word_encoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .value_i         (value_i),
    .flight_phase_i  (flight_phase_i),
    .phase_present_i (phase_present_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .word_o          (word_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Builds the ARINC 429 word that one input item should produce.
  function automatic logic [WORD_W-1:0] encode_arinc_word(enc_item_t it);
    logic [WORD_W-1:0] w;
    logic              neg;
    longint unsigned   mag;
    longint unsigned   cnt;
    logic              exact;
    logic [3:0]        digit;
    int                ndig;
    int                pos;
    w = '0;
    neg = it.value[VALUE_W-1];
    mag = 64'(it.value);
    if (neg) begin
      mag = 64'h800_0000 - mag;
    end
    case (it.func)
      FUNC_ALT: begin
        // BNR count rounds half away from zero; resolution is 625/1024.
        cnt = (mag + 312) / 625;
        if (neg) begin
          exact = (mag % 625 == 0) && (cnt >= 1) && (cnt <= 65536);
          w[27:12] = 16'(64'd0 - cnt);
        end else begin
          exact = (mag % 625 == 0) && (cnt <= 65535);
          w[27:12] = 16'(cnt);
        end
        w[7:0] = LABEL_ALT;
        w[28] = neg;
        if (it.phase_present) begin
          w[11:10] = it.phase;
        end
        if (exact) begin
          w[30:29] = 2'b11;
        end
      end
      FUNC_CLIMB, FUNC_AOA: begin
        // Tenths count, low digits only, most significant kept digit at bits 28..25.
        cnt = (mag * 10 + 512) / 1024;
        ndig = (it.func == FUNC_CLIMB) ? 4 : 3;
        w[7:0] = (it.func == FUNC_CLIMB) ? LABEL_CLIMB : LABEL_AOA;
        for (int k = 0; k < ndig; k++) begin
          digit = 4'(cnt % 10);
          cnt = cnt / 10;
          pos = 25 - 4 * (ndig - 1 - k);
          w = w | (32'(digit) << pos);
        end
        if (neg) begin
          w[30:29] = 2'b11;
        end
      end
      default: begin
        // Unknown label: no computed data.
        w[29] = 1'b1;
      end
    endcase
    w[31] = ~^w[30:0];
    return w;
  endfunction

  task automatic add_item(logic [1:0] f, int v, logic [1:0] ph, logic pp);
    enc_item_t it;
    it.func = f;
    it.value = VALUE_W'(v);
    it.phase = ph;
    it.phase_present = pp;
    pending_items.push_back(it);
  endtask

  task automatic note_mismatch(string what, logic [WORD_W-1:0] exp_w,
                               logic [WORD_W-1:0] act_w);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected %h, got %h", $realtime, what, exp_w, act_w);
    end
  endtask

  // Input driver: presents queued items and records the expected word of each transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_words.push_back(encode_arinc_word(cur_item));
      end
      if ($urandom_range(0, 99) == 0) begin
        src_idle_pct = $urandom_range(0, 3) * 15;
      end
      calm = (pending_items.size() < 150);
      if (!in_valid_i || in_ready_o) begin
        if (src_idle_left > 0) begin
          src_idle_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
          src_idle_left = $urandom_range(1, 11) - 1;
          in_valid_i <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          func_i <= cur_item.func;
          value_i <= cur_item.value;
          flight_phase_i <= cur_item.phase;
          phase_present_i <= cur_item.phase_present;
        end
      end
    end
  end

  // Output monitor: checks each word transfer and stalls the output at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          note_mismatch("word with no item pending", '0, word_o);
        end else begin
          if (word_o !== expected_words[0]) begin
            note_mismatch("word mismatch", expected_words[0], word_o);
          end
          void'(expected_words.pop_front());
        end
      end
      if ($urandom_range(0, 99) == 0) begin
        snk_idle_pct = $urandom_range(0, 3) * 15;
      end
      if (snk_idle_left > 0) begin
        snk_idle_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < snk_idle_pct) begin
        snk_idle_left = $urandom_range(1, 11) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int      mode;
    int      mag;
    bit      neg;
    int      v;
    logic [1:0] f;

    // Directed items: field extremes, rounding edges, range edges and unknown label.
    add_item(FUNC_ALT, 0, 2'd0, 1'b1);
    add_item(FUNC_ALT, 67108863, 2'd3, 1'b1);
    add_item(FUNC_ALT, -67108864, 2'd2, 1'b0);
    add_item(FUNC_ALT, 65535 * 625, 2'd1, 1'b1);
    add_item(FUNC_ALT, 65536 * 625, 2'd2, 1'b1);
    add_item(FUNC_ALT, -65536 * 625, 2'd3, 1'b0);
    add_item(FUNC_ALT, -1, 2'd0, 1'b1);
    add_item(FUNC_ALT, -625, 2'd3, 1'b1);
    add_item(FUNC_ALT, 625 * 7 + 312, 2'd1, 1'b1);
    add_item(FUNC_ALT, 625 * 7 + 313, 2'd2, 1'b1);
    add_item(FUNC_ALT, -(625 * 3 + 313), 2'd1, 1'b1);
    add_item(FUNC_CLIMB, 0, 2'd3, 1'b1);
    add_item(FUNC_CLIMB, 67108863, 2'd0, 1'b0);
    add_item(FUNC_CLIMB, -67108864, 2'd0, 1'b0);
    add_item(FUNC_CLIMB, -1, 2'd0, 1'b0);
    add_item(FUNC_CLIMB, 256, 2'd0, 1'b0);
    add_item(FUNC_CLIMB, 255, 2'd0, 1'b0);
    add_item(FUNC_CLIMB, 1024000, 2'd0, 1'b0);
    add_item(FUNC_CLIMB, 1023898, 2'd0, 1'b0);
    add_item(FUNC_AOA, 0, 2'd0, 1'b0);
    add_item(FUNC_AOA, 102400, 2'd0, 1'b0);
    add_item(FUNC_AOA, -102297, 2'd3, 1'b1);
    add_item(FUNC_AOA, 67108863, 2'd0, 1'b0);
    add_item(FUNC_UNUSED, 0, 2'd3, 1'b1);
    add_item(FUNC_UNUSED, -67108864, 2'd0, 1'b0);

    // Random items biased toward rounding and range edges of both codings.
    for (int n = 0; n < 1200; n++) begin
      mode = $urandom_range(0, 5);
      neg = $urandom_range(0, 1);
      case (mode)
        0: mag = $urandom_range(0, 67108864);
        1: mag = $urandom_range(0, 200000);
        2: mag = 625 * $urandom_range(0, 65536);
        3: mag = 625 * $urandom_range(0, 65600) + 312 + $urandom_range(0, 1);
        4: mag = 256 + 512 * $urandom_range(0, 131070);
        default: mag = 625 * $urandom_range(65534, 65537) + $urandom_range(0, 4) - 2;
      endcase
      if (mag < 0) begin
        mag = 0;
      end
      if (!neg && mag > 67108863) begin
        mag = 67108863;
      end
      v = neg ? -mag : mag;
      if (mode == 0 && $urandom_range(0, 1) == 1) begin
        v = int'($urandom() & 32'h07FF_FFFF);
        v = (v >= 67108864) ? v - 134217728 : v;
      end
      f = ($urandom_range(0, 9) == 0) ? FUNC_UNUSED : 2'($urandom_range(1, 3));
      add_item(f, v, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || in_valid_i || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (NUM_STAGES + 4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/a429enc_pkg.sv
rtl/a429enc_bnr.sv
rtl/a429enc_bcd.sv
rtl/a429enc_pack.sv
rtl/arinc429_word_encoder.sv
dv/arinc429_word_encoder_tb.sv
